// ===== src/aacas_pkg.sv =====
// package: shared types, constants and the arctangent table of the arc stepper
package aacas_pkg;

   localparam int unsigned FULL_TURN = 5760;
   localparam int unsigned DEG45 = 184320;
   localparam int unsigned DEG90 = 368640;
   localparam int unsigned SQRT_STEPS = 28;
   localparam int unsigned CORDIC_STEPS = 18;
   localparam int unsigned ITER_W = 5;
   localparam int unsigned ANGLE_W = 19;
   localparam int unsigned ADJ_W = 21;
   localparam int unsigned Z_W = 22;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_START  = 7'b0000010,
      ST_MUL    = 7'b0000100,
      ST_SQRT   = 7'b0001000,
      ST_ANGLE  = 7'b0010000,
      ST_CORDIC = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   // rounded arctangent of 2^-i in 1/4096 degree
   function automatic logic [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
      logic [Z_W-1:0] v;
      case (idx)
         5'd0: v = 22'd184320;
         5'd1: v = 22'd108810;
         5'd2: v = 22'd57492;
         5'd3: v = 22'd29184;
         5'd4: v = 22'd14649;
         5'd5: v = 22'd7331;
         5'd6: v = 22'd3667;
         5'd7: v = 22'd1833;
         5'd8: v = 22'd917;
         5'd9: v = 22'd458;
         5'd10: v = 22'd229;
         5'd11: v = 22'd115;
         5'd12: v = 22'd57;
         5'd13: v = 22'd29;
         5'd14: v = 22'd14;
         5'd15: v = 22'd7;
         5'd16: v = 22'd4;
         5'd17: v = 22'd2;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== src/antialiased_circle_arc_stepper.sv =====
// top level: wu-style anti-aliased circle arc stepper
//
//  channel | ports            | direction | moves
//  --------+------------------+-----------+----------------------------------
//  req     | req_valid/stall  | in        | start or advance beat
//  rsp     | rsp_valid/stall  | out       | pixel beat, up to 16 per advance
//
// a start beat passes through the start state and gives its single result beat
// an advance beat runs the bit-pair square root, then the cordic arctangent
// (skipped on the exact angles), then gives one result beat per cycle
// while the output does not stall
// req_stall stays high from acceptance until the last result beat is loaded
// into the output register; rsp_stall holds that register and stalls the start and emit states
// reset is synchronous, active high, and clears the walk state to zero except row_y
module antialiased_circle_arc_stepper (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic signed [15:0] req_center_x,
   input  logic signed [15:0] req_center_y,
   input  logic [11:0]        req_radius,
   input  logic signed [13:0] req_start_angle,
   input  logic signed [13:0] req_sweep_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_pixel_x,
   output logic signed [15:0] rsp_pixel_y,
   output logic [7:0]         rsp_pen_weight,
   output logic               rsp_pixel_valid,
   output logic               rsp_last_of_step,
   output logic               rsp_arc_done
);

   // sequencer
   aacas_pkg::state_type state_ff, state_in;
   logic [aacas_pkg::ITER_W-1:0] iter_ff, iter_in;

   // walk state
   logic [11:0] step_x_ff, step_x_in;
   logic [11:0] step_y_ff, step_y_in;
   logic [11:0] row_y_ff, row_y_in;
   logic [15:0] prev_fraction_ff, prev_fraction_in;
   logic signed [15:0] saved_center_x_ff, saved_center_x_in;
   logic signed [15:0] saved_center_y_ff, saved_center_y_in;
   logic [11:0] saved_radius_ff, saved_radius_in;
   logic [23:0] radius_sq_ff, radius_sq_in;
   logic [12:0] range_low_ff, range_low_in;
   logic [12:0] range_high_ff, range_high_in;

   // square root unit
   logic [55:0] sq_op_ff, sq_op_in;
   logic [29:0] sq_rem_ff, sq_rem_in;
   logic [27:0] sq_root_ff, sq_root_in;

   // cordic unit
   logic signed [31:0] cx_ff, cx_in;
   logic signed [31:0] cy_ff, cy_in;
   logic signed [aacas_pkg::Z_W-1:0] z_ff, z_in;
   logic [aacas_pkg::ANGLE_W-1:0] angle_ff, angle_in;

   // row results
   logic [7:0] wt_ff, wt_in;
   logic [7:0] mask_ff, mask_in;
   logic       phase_ff, phase_in;
   logic       done_ff, done_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_x_ff, rsp_x_in;
   logic signed [15:0] rsp_y_ff, rsp_y_in;
   logic [7:0]         rsp_w_ff, rsp_w_in;
   logic               rsp_pv_ff, rsp_pv_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_done_ff, rsp_done_in;

   logic req_take;
   logic out_free;

   // start-beat angle handling
   logic signed [14:0] end_a, end_b, end_lo, end_hi;

   // datapath temporaries
   logic [23:0] y_sq;
   logic [31:0] sq_temp, sq_trial;
   logic [15:0] frac_t;
   logic [11:0] x_new;
   logic [23:0] wt_full;
   logic signed [31:0] cx_sh, cy_sh;
   logic signed [aacas_pkg::Z_W-1:0] z_next;
   logic [aacas_pkg::ANGLE_W-1:0] angle_clamped;
   logic [aacas_pkg::ADJ_W-1:0] lo_q, hi_q;
   logic [aacas_pkg::ADJ_W-1:0] adj [8];
   logic [7:0] paint;
   logic [2:0] oct_sel;
   logic [7:0] mask_rest;
   logic signed [15:0] oct_px, oct_py;
   logic [aacas_pkg::ADJ_W-1:0] deg90_q;
   logic [aacas_pkg::ADJ_W-1:0] a_ext;

   // reduce one end of the arc into 0..FULL_TURN
   // an end spans -16384..16382, so at most two turns down or three up
   function automatic logic [12:0] wrap_angle(input logic signed [14:0] v);
      logic signed [14:0] t;
      t = v;
      if (t > 15'sd5760) begin
         t = t - 15'sd5760;
      end
      if (t > 15'sd5760) begin
         t = t - 15'sd5760;
      end
      if (t < 15'sd0) begin
         t = t + 15'sd5760;
      end
      if (t < 15'sd0) begin
         t = t + 15'sd5760;
      end
      if (t < 15'sd0) begin
         t = t + 15'sd5760;
      end
      return t[12:0];
   endfunction

   // arithmetic shift that truncates toward zero, like a signed division
   function automatic logic signed [31:0] shift_tz(input logic signed [31:0] v,
                                                   input logic [aacas_pkg::ITER_W-1:0] sh);
      logic signed [31:0] r;
      if (v < 0) begin
         r = -((-v) >>> sh);
      end else begin
         r = v >>> sh;
      end
      return r;
   endfunction

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != aacas_pkg::ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_x = rsp_x_ff;
   assign rsp_pixel_y = rsp_y_ff;
   assign rsp_pen_weight = rsp_w_ff;
   assign rsp_pixel_valid = rsp_pv_ff;
   assign rsp_last_of_step = rsp_last_ff;
   assign rsp_arc_done = rsp_done_ff;

   // arc ends in order
   always_comb begin
      end_a = 15'(req_start_angle);
      end_b = 15'(req_start_angle) + 15'(req_sweep_angle);
      if (end_a > end_b) begin
         end_lo = end_b;
         end_hi = end_a;
      end else begin
         end_lo = end_a;
         end_hi = end_b;
      end
   end

   // shared datapath pieces
   assign y_sq = step_y_ff * step_y_ff;
   assign sq_temp = {sq_rem_ff, sq_op_ff[55:54]};
   assign sq_trial = {2'b00, sq_root_ff, 2'b01};
   assign frac_t = 16'd0 - sq_root_ff[15:0];
   assign x_new = (frac_t < prev_fraction_ff) ? step_x_ff - 12'd1 : step_x_ff;
   assign wt_full = {frac_t, 8'd0} - {8'd0, frac_t} + 24'd32768;
   assign cx_sh = shift_tz(cx_ff, iter_ff);
   assign cy_sh = shift_tz(cy_ff, iter_ff);
   assign z_next = (cy_ff > 0) ? z_ff + aacas_pkg::atan_entry(iter_ff)
                               : z_ff - aacas_pkg::atan_entry(iter_ff);

   always_comb begin
      if (z_next < 0) begin
         angle_clamped = '0;
      end else if (z_next > aacas_pkg::Z_W'(aacas_pkg::DEG90)) begin
         angle_clamped = aacas_pkg::ANGLE_W'(aacas_pkg::DEG90);
      end else begin
         angle_clamped = z_next[aacas_pkg::ANGLE_W-1:0];
      end
   end

   // angle of each mirrored octant and the open range test
   assign deg90_q = aacas_pkg::ADJ_W'(aacas_pkg::DEG90);
   assign a_ext = aacas_pkg::ADJ_W'(angle_ff);
   assign lo_q = {range_low_ff, 8'd0};
   assign hi_q = {range_high_ff, 8'd0};

   always_comb begin
      adj[0] = a_ext;
      adj[1] = deg90_q - a_ext;
      adj[2] = deg90_q + a_ext;
      adj[3] = (deg90_q << 1) - a_ext;
      adj[4] = (deg90_q << 1) + a_ext;
      adj[5] = (deg90_q << 1) + deg90_q - a_ext;
      adj[6] = (deg90_q << 1) + deg90_q + a_ext;
      adj[7] = (deg90_q << 2) - a_ext;
      for (int i = 0; i < 8; i++) begin
         paint[i] = (adj[i] > lo_q) && (adj[i] < hi_q);
      end
   end

   // next painted octant and its point before the center offset
   always_comb begin
      logic signed [15:0] xs, ys;
      oct_sel = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (mask_ff[i]) begin
            oct_sel = 3'(i);
         end
      end
      mask_rest = mask_ff & ~(8'd1 << oct_sel);
      xs = 16'($signed({4'd0, step_x_ff}));
      ys = 16'($signed({4'd0, row_y_ff}));
      case (oct_sel)
         3'd0: begin oct_px = xs; oct_py = ys; end
         3'd1: begin oct_px = ys; oct_py = xs; end
         3'd2: begin oct_px = -ys - 16'sd1; oct_py = xs; end
         3'd3: begin oct_px = -xs; oct_py = ys; end
         3'd4: begin oct_px = -xs; oct_py = -ys; end
         3'd5: begin oct_px = -ys - 16'sd1; oct_py = 16'sd1 - xs; end
         3'd6: begin oct_px = ys; oct_py = 16'sd1 - xs; end
         default: begin oct_px = xs; oct_py = -ys; end
      endcase
   end

   // sequencer and datapath
   always_comb begin
      logic flip, horiz;
      logic [7:0] w_pt, w_nb;
      state_in = state_ff;
      iter_in = iter_ff;
      step_x_in = step_x_ff;
      step_y_in = step_y_ff;
      row_y_in = row_y_ff;
      prev_fraction_in = prev_fraction_ff;
      saved_center_x_in = saved_center_x_ff;
      saved_center_y_in = saved_center_y_ff;
      saved_radius_in = saved_radius_ff;
      radius_sq_in = radius_sq_ff;
      range_low_in = range_low_ff;
      range_high_in = range_high_ff;
      sq_op_in = sq_op_ff;
      sq_rem_in = sq_rem_ff;
      sq_root_in = sq_root_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      z_in = z_ff;
      angle_in = angle_ff;
      wt_in = wt_ff;
      mask_in = mask_ff;
      phase_in = phase_ff;
      done_in = done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_w_in = rsp_w_ff;
      rsp_pv_in = rsp_pv_ff;
      rsp_last_in = rsp_last_ff;
      rsp_done_in = rsp_done_ff;
      flip = (oct_sel >= 3'd3) && (oct_sel <= 3'd6);
      horiz = (oct_sel == 3'd1) || (oct_sel == 3'd2) || (oct_sel == 3'd5) ||
              (oct_sel == 3'd6);
      w_pt = flip ? wt_ff : 8'd255 - wt_ff;
      w_nb = flip ? 8'd255 - wt_ff : wt_ff;

      case (state_ff)
         aacas_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_kind == aacas_pkg::KIND_START) begin
                  saved_center_x_in = req_center_x;
                  saved_center_y_in = req_center_y;
                  saved_radius_in = req_radius;
                  radius_sq_in = req_radius * req_radius;
                  range_low_in = wrap_angle(end_lo);
                  range_high_in = wrap_angle(end_hi);
                  step_x_in = req_radius;
                  step_y_in = '0;
                  prev_fraction_in = '0;
                  state_in = aacas_pkg::ST_START;
               end else if (step_x_ff > step_y_ff) begin
                  state_in = aacas_pkg::ST_MUL;
               end else begin
                  // walk already finished: one empty beat
                  mask_in = '0;
                  done_in = 1'b1;
                  state_in = aacas_pkg::ST_EMIT;
               end
            end
         end
         aacas_pkg::ST_START: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pv_in = (range_low_ff == 13'd0) &&
                           (range_high_ff == 13'(aacas_pkg::FULL_TURN));
               rsp_x_in = rsp_pv_in ? saved_center_x_ff + 16'($signed({4'd0, saved_radius_ff}))
                                    : 16'sd0;
               rsp_y_in = rsp_pv_in ? saved_center_y_ff : 16'sd0;
               rsp_w_in = rsp_pv_in ? 8'd255 : 8'd0;
               rsp_last_in = 1'b1;
               rsp_done_in = (saved_radius_ff == 12'd0);
               state_in = aacas_pkg::ST_IDLE;
            end
         end
         aacas_pkg::ST_MUL: begin
            sq_op_in = {(radius_sq_ff > y_sq) ? radius_sq_ff - y_sq : 24'd0, 32'd0};
            sq_rem_in = '0;
            sq_root_in = '0;
            iter_in = '0;
            state_in = aacas_pkg::ST_SQRT;
         end
         aacas_pkg::ST_SQRT: begin
            // one root bit from each operand bit pair per cycle
            if (sq_temp >= sq_trial) begin
               sq_rem_in = 30'(sq_temp - sq_trial);
               sq_root_in = {sq_root_ff[26:0], 1'b1};
            end else begin
               sq_rem_in = sq_temp[29:0];
               sq_root_in = {sq_root_ff[26:0], 1'b0};
            end
            sq_op_in = {sq_op_ff[53:0], 2'b00};
            iter_in = iter_ff + 5'd1;
            if (iter_ff == aacas_pkg::ITER_W'(aacas_pkg::SQRT_STEPS - 1)) begin
               state_in = aacas_pkg::ST_ANGLE;
            end
         end
         aacas_pkg::ST_ANGLE: begin
            step_x_in = x_new;
            prev_fraction_in = frac_t;
            wt_in = wt_full[23:16];
            row_y_in = step_y_ff;
            cx_in = 32'($signed({4'd0, x_new, 16'd0}));
            cy_in = 32'($signed({4'd0, step_y_ff, 16'd0}));
            z_in = '0;
            iter_in = '0;
            if (step_y_ff == 12'd0) begin
               angle_in = '0;
               state_in = aacas_pkg::ST_CORDIC;
               iter_in = aacas_pkg::ITER_W'(aacas_pkg::CORDIC_STEPS);
            end else if (x_new == step_y_ff) begin
               angle_in = aacas_pkg::ANGLE_W'(aacas_pkg::DEG45);
               state_in = aacas_pkg::ST_CORDIC;
               iter_in = aacas_pkg::ITER_W'(aacas_pkg::CORDIC_STEPS);
            end else begin
               state_in = aacas_pkg::ST_CORDIC;
            end
         end
         aacas_pkg::ST_CORDIC: begin
            if (iter_ff == aacas_pkg::ITER_W'(aacas_pkg::CORDIC_STEPS)) begin
               // angle settled: pick the octants, close the row
               mask_in = paint;
               phase_in = 1'b0;
               step_y_in = step_y_ff + 12'd1;
               done_in = step_x_ff <= step_y_ff + 12'd1;
               state_in = aacas_pkg::ST_EMIT;
            end else begin
               if (cy_ff > 0) begin
                  cx_in = cx_ff + cy_sh;
                  cy_in = cy_ff - cx_sh;
               end else begin
                  cx_in = cx_ff - cy_sh;
                  cy_in = cy_ff + cx_sh;
               end
               z_in = z_next;
               iter_in = iter_ff + 5'd1;
               if (iter_ff == aacas_pkg::ITER_W'(aacas_pkg::CORDIC_STEPS - 1)) begin
                  angle_in = angle_clamped;
               end
            end
         end
         aacas_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_done_in = done_ff;
               if (mask_ff == 8'd0) begin
                  rsp_pv_in = 1'b0;
                  rsp_x_in = '0;
                  rsp_y_in = '0;
                  rsp_w_in = '0;
                  rsp_last_in = 1'b1;
                  state_in = aacas_pkg::ST_IDLE;
               end else if (!phase_ff) begin
                  rsp_pv_in = 1'b1;
                  rsp_x_in = oct_px + saved_center_x_ff;
                  rsp_y_in = oct_py + saved_center_y_ff;
                  rsp_w_in = w_pt;
                  rsp_last_in = 1'b0;
                  phase_in = 1'b1;
               end else begin
                  // neighbor one below in y or one left in x
                  rsp_pv_in = 1'b1;
                  rsp_x_in = oct_px + saved_center_x_ff - (horiz ? 16'sd0 : 16'sd1);
                  rsp_y_in = oct_py + saved_center_y_ff - (horiz ? 16'sd1 : 16'sd0);
                  rsp_w_in = w_nb;
                  rsp_last_in = (mask_rest == 8'd0);
                  phase_in = 1'b0;
                  mask_in = mask_rest;
                  if (mask_rest == 8'd0) begin
                     state_in = aacas_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = aacas_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aacas_pkg::ST_IDLE;
         iter_ff <= '0;
         step_x_ff <= '0;
         step_y_ff <= '0;
         prev_fraction_ff <= '0;
         saved_center_x_ff <= '0;
         saved_center_y_ff <= '0;
         saved_radius_ff <= '0;
         radius_sq_ff <= '0;
         range_low_ff <= '0;
         range_high_ff <= '0;
         mask_ff <= '0;
         phase_ff <= 1'b0;
         done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         iter_ff <= iter_in;
         step_x_ff <= step_x_in;
         step_y_ff <= step_y_in;
         prev_fraction_ff <= prev_fraction_in;
         saved_center_x_ff <= saved_center_x_in;
         saved_center_y_ff <= saved_center_y_in;
         saved_radius_ff <= saved_radius_in;
         radius_sq_ff <= radius_sq_in;
         range_low_ff <= range_low_in;
         range_high_ff <= range_high_in;
         mask_ff <= mask_in;
         phase_ff <= phase_in;
         done_ff <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_y_ff <= row_y_in;
      sq_op_ff <= sq_op_in;
      sq_rem_ff <= sq_rem_in;
      sq_root_ff <= sq_root_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      z_ff <= z_in;
      angle_ff <= angle_in;
      wt_ff <= wt_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_w_ff <= rsp_w_in;
      rsp_pv_ff <= rsp_pv_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   // the walk never steps x beyond the latched radius
   assert property (@(posedge clock) disable iff (reset)
      step_x_ff <= saved_radius_ff)
      else $error("step_x above radius");

   // the root iteration count stays inside the square root pass
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == aacas_pkg::ST_SQRT) |-> (iter_ff < 5'(aacas_pkg::SQRT_STEPS)))
      else $error("square root overran");

   // an empty row gives exactly one beat and then frees the input
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == aacas_pkg::ST_EMIT && mask_ff == 8'd0 && out_free)
      |=> (state_ff == aacas_pkg::ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("empty row not closed");

endmodule
